/* hw/rtl/weno5_pkg.sv */
package weno5_pkg;

   localparam int MAX_POINTS_DEF = 4096;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_GRID_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY      = 2'd2;

   localparam logic [30:0] INV_GRID_STEP_RST = 31'd65536;
   localparam logic [30:0] TIME_STEP_RST     = 31'd655;
   localparam logic [31:0] VELOCITY_RST      = 32'd65536;

   localparam logic [63:0]  EPS_Q32  = 64'd4;
   localparam logic [111:0] TERM_CAP = 112'd1 << 40;

   // (2^65 + 1) / 3: floor(m / 3) = (m * RECIP3) >> 65 for any 64-bit m
   localparam logic [63:0]  RECIP3   = 64'hAAAA_AAAA_AAAA_AAAB;

   // micro-step numbers
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] ST_DIFF  = 5'd0;   // five steps
   localparam logic [STEP_W-1:0] ST_CAND  = 5'd5;
   localparam logic [STEP_W-1:0] ST_SQX   = 5'd6;   // three steps
   localparam logic [STEP_W-1:0] ST_DIV12 = 5'd9;   // three steps
   localparam logic [STEP_W-1:0] ST_SQY   = 5'd12;  // three steps
   localparam logic [STEP_W-1:0] ST_NORM  = 5'd15;
   localparam logic [STEP_W-1:0] ST_RATIO = 5'd16;  // three steps
   localparam logic [STEP_W-1:0] ST_HSQ   = 5'd19;  // three steps
   localparam logic [STEP_W-1:0] ST_NUM   = 5'd22;  // three steps
   localparam logic [STEP_W-1:0] ST_FLUX  = 5'd25;
   localparam logic [STEP_W-1:0] ST_COEF  = 5'd26;
   localparam logic [STEP_W-1:0] ST_TERM  = 5'd27;
   localparam logic [STEP_W-1:0] ST_LAST  = ST_TERM;

   // step groups
   localparam logic [3:0] G_DIFF  = 4'd0;
   localparam logic [3:0] G_CAND  = 4'd1;
   localparam logic [3:0] G_SQX   = 4'd2;
   localparam logic [3:0] G_DIV12 = 4'd3;
   localparam logic [3:0] G_SQY   = 4'd4;
   localparam logic [3:0] G_NORM  = 4'd5;
   localparam logic [3:0] G_RATIO = 4'd6;
   localparam logic [3:0] G_HSQ   = 4'd7;
   localparam logic [3:0] G_NUM   = 4'd8;
   localparam logic [3:0] G_FLUX  = 4'd9;
   localparam logic [3:0] G_COEF  = 4'd10;
   localparam logic [3:0] G_TERM  = 4'd11;

   // step kinds
   localparam logic [1:0] K_MUL   = 2'd0;
   localparam logic [1:0] K_DIV   = 2'd1;
   localparam logic [1:0] K_LOCAL = 2'd2;
   localparam logic [1:0] K_NORM  = 2'd3;

   typedef struct packed {
      logic              shift;
      logic              start;
      logic [STEP_W-1:0] step;
      logic              load_out;
      logic [11:0]       cidx;
   } cmd_type;

   typedef struct packed {
      logic done;
   } sts_type;

   function automatic logic [3:0] step_group(input logic [STEP_W-1:0] s);
      priority if (s < ST_CAND)  return G_DIFF;
      else if (s < ST_SQX)       return G_CAND;
      else if (s < ST_DIV12)     return G_SQX;
      else if (s < ST_SQY)       return G_DIV12;
      else if (s < ST_NORM)      return G_SQY;
      else if (s < ST_RATIO)     return G_NORM;
      else if (s < ST_HSQ)       return G_RATIO;
      else if (s < ST_NUM)       return G_HSQ;
      else if (s < ST_FLUX)      return G_NUM;
      else if (s < ST_COEF)      return G_FLUX;
      else if (s < ST_TERM)      return G_COEF;
      else                       return G_TERM;
   endfunction

   function automatic logic [STEP_W-1:0] group_base(input logic [3:0] g);
      unique case (g)
         G_DIFF:  return ST_DIFF;
         G_CAND:  return ST_CAND;
         G_SQX:   return ST_SQX;
         G_DIV12: return ST_DIV12;
         G_SQY:   return ST_SQY;
         G_NORM:  return ST_NORM;
         G_RATIO: return ST_RATIO;
         G_HSQ:   return ST_HSQ;
         G_NUM:   return ST_NUM;
         G_FLUX:  return ST_FLUX;
         G_COEF:  return ST_COEF;
         default: return ST_TERM;
      endcase
   endfunction

   // divide by 12 runs as a multiply by the reciprocal of 3
   function automatic logic [1:0] group_kind(input logic [3:0] g);
      unique case (g)
         G_RATIO, G_FLUX: return K_DIV;
         G_CAND:          return K_LOCAL;
         G_NORM:          return K_NORM;
         default:         return K_MUL;
      endcase
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

endpackage

/* hw/rtl/weno5_if.sv */
interface weno5_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;
   logic               first_of_row;
   modport source (output valid, output sample, output first_of_row, input ready);
   modport sink   (input valid, input sample, input first_of_row, output ready);
endinterface

interface weno5_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_value;
   logic [11:0]        centre_index;
   modport source (output valid, output new_value, output centre_index, input ready);
   modport sink   (input valid, input new_value, input centre_index, output ready);
endinterface

/* hw/rtl/weno5_mdu.sv */
module weno5_mdu
   import weno5_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         op_div,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod,
   output logic [63:0]  quot
);

   logic         busy_ff, busy_in;
   logic         div_ff;
   logic [127:0] acc_ff, mc_ff;
   logic [63:0]  mp_ff;
   logic [64:0]  rem_ff;
   logic [63:0]  dvd_ff, dsr_ff;
   logic [6:0]   cnt_ff;

   logic [64:0]  rem_sh, rem_sub;
   logic         qbit;

   // shift-add multiply stops when the multiplier runs out of ones;
   // restoring divide takes one quotient bit per cycle
   assign rem_sh  = {rem_ff[63:0], dvd_ff[63]};
   assign qbit    = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   assign done = busy_ff && (div_ff ? (cnt_ff == 7'd64) : (mp_ff == 64'd0));
   assign prod = acc_ff;
   assign quot = dvd_ff;

   always_comb begin
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= op_div;
         acc_ff <= '0;
         mc_ff  <= {64'd0, a};
         mp_ff  <= b;
         rem_ff <= '0;
         dvd_ff <= a;
         dsr_ff <= b;
         cnt_ff <= '0;
      end else if (busy_ff && !done) begin
         if (div_ff) begin
            rem_ff <= qbit ? rem_sub : rem_sh;
            dvd_ff <= {dvd_ff[62:0], qbit};
            cnt_ff <= cnt_ff + 7'd1;
         end else begin
            if (mp_ff[0]) begin
               acc_ff <= acc_ff + mc_ff;
            end
            mc_ff <= {mc_ff[126:0], 1'b0};
            mp_ff <= {1'b0, mp_ff[63:1]};
         end
      end
   end

endmodule

/* hw/rtl/weno5_ctrl.sv */
module weno5_ctrl
   import weno5_pkg::*;
#(
   parameter int MaxPoints = MAX_POINTS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_first,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam int CW = $clog2(MaxPoints + 1);
   localparam int IW = (CW > 12) ? CW : 12;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0]     rc_ff, rc_in, rc_new;
   logic              ov_ff, ov_in;
   logic              accept, taken, emit, load;
   logic [IW-1:0]     idx_wide;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // row count saturates at the row limit; beyond it no result
   always_comb begin
      taken  = 1'b1;
      rc_new = rc_ff;
      if (req_first) begin
         rc_new = CW'(1);
      end else if (rc_ff < CW'(MaxPoints)) begin
         rc_new = rc_ff + CW'(1);
      end else begin
         taken = 1'b0;
      end
   end

   assign emit     = taken && (rc_new >= CW'(6));
   assign rc_in    = accept ? rc_new : rc_ff;
   assign idx_wide = IW'(rc_new) - IW'(3);

   assign load  = (state_ff == S_OUT) && (!ov_ff || rsp_ready);
   assign ov_in = load || (ov_ff && !rsp_ready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && emit) begin
               state_in = S_ISSUE;
               step_in  = ST_DIFF;
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (sts.done) begin
               if (step_ff == ST_LAST) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_ISSUE;
                  step_in  = step_ff + STEP_W'(1);
               end
            end
         end
         S_OUT: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         rc_ff    <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rc_ff    <= rc_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp_valid    = ov_ff;
   assign cmd.shift    = accept;
   assign cmd.start    = (state_ff == S_ISSUE);
   assign cmd.step     = step_ff;
   assign cmd.load_out = load;
   assign cmd.cidx     = idx_wide[11:0];

endmodule

/* hw/rtl/weno5_dp.sv */
module weno5_dp
   import weno5_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic signed [31:0]   req_sample,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic signed [31:0]   rsp_new_value,
   output logic [11:0]          rsp_centre_index
);

   logic [30:0]        inv_ff, dt_ff;
   logic signed [31:0] vel_ff;
   logic signed [31:0] win_ff [6];
   logic [11:0]        cidx_ff;
   logic signed [31:0] d_ff [5];
   logic signed [39:0] n_ff [3];
   logic signed [35:0] x_ff [3];
   logic signed [35:0] y_ff [3];
   logic [63:0]        q_ff [3];
   logic [31:0]        mn_ff;
   logic [16:0]        r_ff [3];
   logic [18:0]        b_ff [3];
   logic [19:0]        bs_ff;
   logic signed [63:0] num_ff;
   logic signed [39:0] flux_ff;
   logic signed [47:0] coef_ff;
   logic signed [31:0] res_ff;
   logic               norm_on_ff, local_done_ff;

   logic [3:0]         grp;
   logic [1:0]         kind;
   logic [STEP_W-1:0]  lane_w;
   logic [2:0]         lane5;
   logic [1:0]         lane3;
   logic signed [32:0] diff [5];
   logic signed [32:0] diff_sel;
   logic [63:0]        op_a, op_b, x_mag, y_mag, q_sel;
   logic               mdu_start, mdu_done;
   logic [127:0]       prod;
   logic [63:0]        quot;
   logic               norm_hi, norm_done;
   logic [63:0]        q_fix [3];
   logic [31:0]        mn_fix;

   // per-step write-back values
   logic [111:0]       dsh;
   logic [30:0]        d_sat;
   logic signed [31:0] d_val;
   logic [63:0]        sq_val, q_div, q_sqy;
   logic [16:0]        h_val;
   logic [18:0]        b_val;
   logic signed [63:0] m_sgn;
   logic [39:0]        f_mag;
   logic [47:0]        c_mag;
   logic [111:0]       t_sh;
   logic [40:0]        t_mag;
   logic signed [41:0] t_sgn, res_w;
   logic signed [31:0] res_sat;
   logic [22:0]        bs6;
   logic signed [39:0] dx [5];
   logic signed [39:0] n_c [3];
   logic signed [39:0] x_c [3];
   logic signed [39:0] y_c [3];

   assign grp    = step_group(cmd.step);
   assign kind   = group_kind(grp);
   assign lane_w = cmd.step - group_base(grp);
   assign lane5  = lane_w[2:0];
   assign lane3  = lane_w[1:0];

   for (genvar k = 0; k < 5; k++) begin : g_diff
      assign diff[k] = 33'(win_ff[k+1]) - 33'(win_ff[k]);
      assign dx[k]   = 40'(d_ff[k]);
   end

   assign diff_sel = diff[lane5];
   assign x_mag    = mag64(64'(x_ff[lane3]));
   assign y_mag    = mag64(64'(y_ff[lane3]));
   assign q_sel    = q_ff[lane3];
   assign bs6      = 23'({bs_ff, 2'b00}) + 23'({bs_ff, 1'b0});

   // candidates (six times the slope) and indicator operands
   assign n_c[0] = 2 * dx[0] - 7 * dx[1] + 11 * dx[2];
   assign n_c[1] = -dx[1] + 5 * dx[2] + 2 * dx[3];
   assign n_c[2] = 2 * dx[2] + 5 * dx[3] - dx[4];
   assign x_c[0] = dx[0] - 2 * dx[1] + dx[2];
   assign y_c[0] = dx[0] - 4 * dx[1] + 3 * dx[2];
   assign x_c[1] = dx[1] - 2 * dx[2] + dx[3];
   assign y_c[1] = dx[1] - dx[3];
   assign x_c[2] = dx[2] - 2 * dx[3] + dx[4];
   assign y_c[2] = 3 * dx[2] - 4 * dx[3] + dx[4];

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (grp)
         G_DIFF: begin
            op_a = mag64(64'(diff_sel));
            op_b = 64'(inv_ff);
         end
         G_SQX: begin
            op_a = x_mag;
            op_b = x_mag;
         end
         G_DIV12: begin
            // q/12 = (q>>2)/3, taken as a multiply by the reciprocal of 3
            op_a = RECIP3;
            op_b = {2'b00, q_sel[63:2]};
         end
         G_SQY: begin
            op_a = y_mag;
            op_b = y_mag;
         end
         G_RATIO: begin
            op_a = {16'd0, mn_ff, 16'd0};
            op_b = {32'd0, q_sel[31:0]};
         end
         G_HSQ: begin
            op_a = 64'(r_ff[lane3]);
            op_b = 64'(r_ff[lane3]);
         end
         G_NUM: begin
            op_a = mag64(64'(n_ff[lane3]));
            op_b = 64'(b_ff[lane3]);
         end
         G_FLUX: begin
            op_a = mag64(num_ff);
            op_b = 64'(bs6);
         end
         G_COEF: begin
            op_a = mag64(64'(vel_ff));
            op_b = 64'(dt_ff);
         end
         G_TERM: begin
            op_a = mag64(64'(coef_ff));
            op_b = mag64(64'(flux_ff));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign mdu_start = cmd.start && ((kind == K_MUL) || (kind == K_DIV));

   weno5_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .start  (mdu_start),
      .op_div (kind == K_DIV),
      .a      (op_a),
      .b      (op_b),
      .done   (mdu_done),
      .prod   (prod),
      .quot   (quot)
   );

   // write-back values
   always_comb begin
      dsh    = prod[127:16];
      d_sat  = (|dsh[111:31]) ? 31'h7FFF_FFFF : dsh[30:0];
      d_val  = diff_sel[32] ? -signed'({1'b0, d_sat}) : signed'({1'b0, d_sat});
      sq_val = (|((grp == G_SQX) ? x_mag[63:32] : y_mag[63:32])) ? '1 : prod[63:0];
      q_div  = sat_add64(q_sel, {1'b0, prod[127:65]});
      q_sqy  = sat_add64(sat_add64(q_sel, {2'b00, sq_val[63:2]}), EPS_Q32);
      h_val  = prod[32:16];
      unique case (lane3)
         2'd1:    b_val = 19'({h_val, 2'b00}) + 19'({h_val, 1'b0});
         2'd2:    b_val = 19'({h_val, 1'b0}) + 19'(h_val);
         default: b_val = 19'(h_val);
      endcase
      m_sgn  = n_ff[lane3][39] ? -signed'(prod[63:0]) : signed'(prod[63:0]);
      f_mag  = quot[39:0];
      c_mag  = prod[63:16];
      t_sh   = prod[127:16];
      t_mag  = (t_sh > TERM_CAP) ? TERM_CAP[40:0] : t_sh[40:0];
      t_sgn  = (coef_ff[47] ^ flux_ff[39]) ? -signed'({1'b0, t_mag})
                                            : signed'({1'b0, t_mag});
      res_w  = 42'(win_ff[3]) - t_sgn;
      priority if (res_w > 42'sh0_7FFF_FFFF)       res_sat = 32'sh7FFF_FFFF;
      else if (res_w < -42'sh0_8000_0000)          res_sat = 32'sh8000_0000;
      else                                         res_sat = res_w[31:0];
   end

   // normalize: shift all three until each fits 32 bits
   assign norm_hi   = (|q_ff[0][63:32]) || (|q_ff[1][63:32]) || (|q_ff[2][63:32]);
   assign norm_done = norm_on_ff && !norm_hi;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q_fix[k] = (q_ff[k] == 64'd0) ? 64'd1 : q_ff[k];
      end
      mn_fix = q_fix[0][31:0];
      if (q_fix[1][31:0] < mn_fix) mn_fix = q_fix[1][31:0];
      if (q_fix[2][31:0] < mn_fix) mn_fix = q_fix[2][31:0];
   end

   assign sts.done = local_done_ff || norm_done || mdu_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff        <= INV_GRID_STEP_RST;
         dt_ff         <= TIME_STEP_RST;
         vel_ff        <= VELOCITY_RST;
         norm_on_ff    <= 1'b0;
         local_done_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_INV_GRID_STEP: inv_ff <= csr_wdata[30:0];
               CSR_TIME_STEP:     dt_ff  <= csr_wdata[30:0];
               CSR_VELOCITY:      vel_ff <= csr_wdata;
               default:           ;
            endcase
         end
         local_done_ff <= cmd.start && (kind == K_LOCAL);
         if (cmd.start && (kind == K_NORM)) begin
            norm_on_ff <= 1'b1;
         end else if (norm_done) begin
            norm_on_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int k = 0; k < 5; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[5] <= req_sample;
         cidx_ff   <= cmd.cidx;
      end
      if (cmd.start && (kind == K_LOCAL)) begin
         for (int k = 0; k < 3; k++) begin
            n_ff[k] <= n_c[k];
            x_ff[k] <= x_c[k][35:0];
            y_ff[k] <= y_c[k][35:0];
         end
         bs_ff  <= '0;
         num_ff <= '0;
      end
      if (norm_on_ff) begin
         if (norm_hi) begin
            for (int k = 0; k < 3; k++) begin
               q_ff[k] <= {1'b0, q_ff[k][63:1]};
            end
         end else begin
            for (int k = 0; k < 3; k++) begin
               q_ff[k] <= q_fix[k];
            end
            mn_ff <= mn_fix;
         end
      end
      if (mdu_done) begin
         unique case (grp)
            G_DIFF:  d_ff[lane5] <= d_val;
            G_SQX:   q_ff[lane3] <= sq_val;
            G_DIV12: q_ff[lane3] <= q_div;
            G_SQY:   q_ff[lane3] <= q_sqy;
            G_RATIO: r_ff[lane3] <= quot[16:0];
            G_HSQ: begin
               b_ff[lane3] <= b_val;
               bs_ff       <= bs_ff + 20'(b_val);
            end
            G_NUM:   num_ff  <= num_ff + m_sgn;
            G_FLUX:  flux_ff <= num_ff[63] ? -signed'(f_mag) : signed'(f_mag);
            G_COEF:  coef_ff <= vel_ff[31] ? -signed'(c_mag) : signed'(c_mag);
            G_TERM:  res_ff  <= res_sat;
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         rsp_new_value    <= res_ff;
         rsp_centre_index <= cidx_ff;
      end
   end

endmodule

/* hw/rtl/weno5_advection_step_core.sv */
// Channel   Dir  Handshake          Payload
// req_chan  in   valid/ready        sample (s32 Q16.16), first_of_row
// rsp_chan  out  valid/ready        new_value (s32 Q16.16), centre_index (12b)
// csr_*     in   csr_we, no wait    csr_index (2b), csr_wdata (32b)
//
// One item at a time. An item that yields no result is taken and the core
// stays ready for the next. An item that yields a result is computed by
// the single bit-serial multiply/divide unit in 28 micro-steps: each
// multiply runs one multiplier bit a cycle, divides are restoring; the
// divide by 12 is a multiply by the reciprocal of 3.
// Synchronous active-high reset; config regs come up at their defaults.
// The finished result sits in an output register, so a stalled rsp side
// only holds the next result, and req is taken again once it is loaded.
module weno5_advection_step_core
   import weno5_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   weno5_req_if.sink            req_chan,
   weno5_rsp_if.source          rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: window count, micro-step order, output slot
   weno5_ctrl #(
      .MaxPoints (MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_first (req_chan.first_of_row),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // window, config, intermediate values and the shared arithmetic unit
   weno5_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample       (req_chan.sample),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_new_value    (rsp_chan.new_value),
      .rsp_centre_index (rsp_chan.centre_index)
   );

endmodule

/* hw/rtl/weno5_chk.sv */
module weno5_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_first,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_new_value,
   input logic [11:0] rsp_centre_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_new_value) && $stable(rsp_centre_index))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_row_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_first |=> req_ready)
      else $error("row start item did not return to idle");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a compute");

endmodule

bind weno5_advection_step_core weno5_chk u_weno5_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_first        (req_chan.first_of_row),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_new_value    (rsp_chan.new_value),
   .rsp_centre_index (rsp_chan.centre_index)
);
